// ----- sv/nng_pkg.sv -----
// shared types and constants for the nearest greater neighbors block
package nng_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 5;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_element;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]        element_index;
    logic                    has_left;
    logic signed [VAL_W-1:0] left_value;
    logic                    has_right;
    logic signed [VAL_W-1:0] right_value;
    logic                    status;
    logic                    run_end;
  } out_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    left_valid;
    logic signed [VAL_W-1:0] left_value;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OVF,
    S_CMP,
    S_PUSH,
    S_FRD,
    S_FEND
  } state_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // result record for one stack entry
  function automatic out_t make_rec(ent_t e, logic hr, logic signed [VAL_W-1:0] rv);
    out_t r;
    r.element_index = e.position;
    r.has_left      = e.left_valid;
    r.left_value    = e.left_valid ? e.left_value : '0;
    r.has_right     = hr;
    r.right_value   = hr ? rv : '0;
    r.status        = STATUS_OK;
    r.run_end       = 1'b0;
    return r;
  endfunction

endpackage

// ----- sv/nearest_greater_neighbors_top.sv -----
// nearest greater neighbors: monotonic stack kept in a synchronous ram
// sequencing: an element is accepted, pops its smaller entries, then is pushed; a last
//   element then flushes each entry, the pushed one included; an overflow element only
//   sends its rejection record; the input stalls until the block is idle again
// throughput: one pop per cycle while the output is not stalled
// reset: synchronous, clears depth, next position and handshake state, never the ram
module nearest_greater_neighbors_top #(
  parameter int MAX_LEN = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  nng_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nng_pkg::out_t out_data
);

  import nng_pkg::*;

  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ENT_W  = $bits(ent_t);

  // control registers
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;       // live stack entries
  logic [CNT_W-1:0] next_pos, next_pos_next; // position of the next element
  logic             pend_valid, pend_valid_next;
  logic             out_valid_next;

  // payload registers
  logic signed [VAL_W-1:0] v_reg, v_reg_next;
  logic                    last_reg, last_reg_next;
  ent_t                    below, below_next;   // entry under the push slot
  logic                    below_ok, below_ok_next;
  out_t                    pend, pend_next;     // record waiting to learn its run_end
  out_t                    out_data_next;

  // ram port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  ent_t              rd_ent;

  logic             accept, out_free, gt;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic [31:0]      np_ext;
  ent_t             new_ent;
  out_t             ovf_rec;

  nng_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_LEN)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_ent   = ent_t'(ram_rdata);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // output slot can take a new transaction this cycle
  assign out_free = !out_valid || !out_stall;
  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign np_ext   = 32'(next_pos);
  assign gt       = (v_reg > rd_ent.value);

  // entry to be pushed: an equal value below shares its left answer
  always_comb begin
    new_ent.value    = v_reg;
    new_ent.position = np_ext[POS_W-1:0];
    if (!below_ok) begin
      new_ent.left_valid = 1'b0;
      new_ent.left_value = '0;
    end else if (below.value == v_reg) begin
      new_ent.left_valid = below.left_valid;
      new_ent.left_value = below.left_value;
    end else begin
      new_ent.left_valid = 1'b1;
      new_ent.left_value = below.value;
    end
  end

  always_comb begin
    ovf_rec         = '0;
    ovf_rec.status  = STATUS_OVERFLOW;
    ovf_rec.run_end = 1'b1;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    next_pos_next   = next_pos;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    v_reg_next      = v_reg;
    last_reg_next   = last_reg;
    below_next      = below;
    below_ok_next   = below_ok;
    out_data_next   = out_data;
    out_valid_next  = out_valid && out_stall;
    ram_we          = 1'b0;
    ram_waddr       = count[ADDR_W-1:0];
    ram_wdata       = ENT_W'(new_ent);
    ram_re          = 1'b0;
    ram_raddr       = cnt_m1[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          v_reg_next    = in_data.value;
          last_reg_next = in_data.last_element;
          below_ok_next = 1'b0;
          if (next_pos >= CNT_W'(MAX_LEN)) begin
            state_next = S_OVF;
          end else if (count != '0) begin
            // fetch the top of stack for the first compare
            ram_re     = 1'b1;
            state_next = S_CMP;
          end else begin
            state_next = S_PUSH;
          end
        end
      end

      S_OVF: begin
        if (out_free) begin
          out_data_next  = ovf_rec;
          out_valid_next = 1'b1;
          if (last_reg) begin
            count_next    = '0;
            next_pos_next = '0;
          end
          state_next = S_IDLE;
        end
      end

      S_CMP: begin
        if (gt) begin
          // pop: the earlier popped record is not the final one
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_data_next  = pend;
              out_valid_next = 1'b1;
            end
            pend_next       = make_rec(rd_ent, 1'b1, v_reg);
            pend_valid_next = 1'b1;
            count_next      = cnt_m1;
            if (count > CNT_W'(1)) begin
              ram_re    = 1'b1;
              ram_raddr = cnt_m2[ADDR_W-1:0];
            end else begin
              below_ok_next = 1'b0;
              state_next    = S_PUSH;
            end
          end
        end else begin
          below_next    = rd_ent;
          below_ok_next = 1'b1;
          state_next    = S_PUSH;
        end
      end

      S_PUSH: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_data_next         = pend;
            out_data_next.run_end = !last_reg;
            out_valid_next        = 1'b1;
          end
          ram_we = 1'b1;
          if (last_reg) begin
            // pushed entry goes straight to the flush as its first record
            pend_next       = make_rec(new_ent, 1'b0, '0);
            pend_valid_next = 1'b1;
            if (count != '0) begin
              ram_re     = 1'b1;
              state_next = S_FRD;
            end else begin
              state_next = S_FEND;
            end
          end else begin
            pend_valid_next = 1'b0;
            count_next      = count + CNT_W'(1);
            next_pos_next   = next_pos + CNT_W'(1);
            state_next      = S_IDLE;
          end
        end
      end

      S_FRD: begin
        if (out_free) begin
          out_data_next  = pend;
          out_valid_next = 1'b1;
          pend_next      = make_rec(rd_ent, 1'b0, '0);
          count_next     = cnt_m1;
          if (count > CNT_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m2[ADDR_W-1:0];
          end else begin
            state_next = S_FEND;
          end
        end
      end

      S_FEND: begin
        if (out_free) begin
          out_data_next         = pend;
          out_data_next.run_end = 1'b1;
          out_valid_next        = 1'b1;
          pend_valid_next       = 1'b0;
          count_next            = '0;
          next_pos_next         = '0;
          state_next            = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      next_pos   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      next_pos   <= next_pos_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    v_reg    <= v_reg_next;
    last_reg <= last_reg_next;
    below    <= below_next;
    below_ok <= below_ok_next;
    pend     <= pend_next;
    out_data <= out_data_next;
  end

  // stack depth never exceeds its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_LEN))
    else $error("stack depth beyond capacity");

  // the stack never holds more entries than elements taken in this run
  a_count_pos: assert property (@(posedge clk) disable iff (rst)
    count <= next_pos)
    else $error("stack deeper than element count");

  // no record is left pending once the block is idle
  a_idle_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending record left at idle");

  // an overflow transaction always closes its input's results
  a_ovf_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_OVERFLOW) |-> out_data.run_end)
    else $error("overflow transaction without run end");

endmodule

// ----- sv/nng_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module nng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the nearest greater neighbors block
`timescale 1ns / 1ps

module testbench;

  import nng_pkg::*;

  localparam int STACK_DEPTH = 32;
  // slowest flush gives one result per stack entry; the drain wait is sized from the depth
  localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 16;

  // kinds of array content the random part draws from
  typedef enum int {
    SHAPE_CLUSTERED,
    SHAPE_FULL,
    SHAPE_FALLING,
    SHAPE_RISING,
    SHAPE_EXTREME
  } shape_t;

  // one entry of the predicted stack
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    logic                    has_left;
    logic signed [VAL_W-1:0] left;
  } slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // sender side of the block, driven to known values from time zero
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;

  // receiver side
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  // stimulus waiting to be offered, and records still owed by the block
  in_t   pending_items[$];
  out_t  owed_records[$];

  int    queued_count = 0;
  int    taken_count = 0;
  int    mismatch_count = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  // predicted stack state
  slot_t       stack_slots[STACK_DEPTH];
  int unsigned stack_depth = 0;
  int unsigned next_pos = 0;

  out_t  seen_rec;
  out_t  want_rec;

  nearest_greater_neighbors_top #(
    .MAX_LEN(STACK_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs or withholds records
  initial begin
    #2_000_000;
    $display("nearest_greater_neighbors_top regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // append one record to the tail of the owed list
  function automatic void owe_record(out_t rec);
    owed_records = {owed_records, rec};
  endfunction

  // record for a stack entry leaving the stack, with or without a right neighbor
  function automatic out_t resolved(slot_t s, logic has_r, logic signed [VAL_W-1:0] rv);
    out_t r;
    r = '0;
    r.element_index = s.pos;
    r.has_left      = s.has_left;
    r.left_value    = s.has_left ? s.left : '0;
    r.has_right     = has_r;
    r.right_value   = has_r ? rv : '0;
    r.status        = STATUS_OK;
    r.run_end       = 1'b0;
    return r;
  endfunction

  // advance the predicted stack by one accepted element and queue its records
  function automatic void predict_neighbors(in_t item);
    out_t  rec;
    slot_t fresh;
    int    produced;
    produced = 0;

    // array already full: one rejection record, and a marked element closes the run
    if (next_pos >= STACK_DEPTH) begin
      rec = '0;
      rec.status  = STATUS_OVERFLOW;
      rec.run_end = 1'b1;
      owe_record(rec);
      if (item.last_element) begin
        stack_depth = 0;
        next_pos = 0;
      end
      return;
    end

    // every strictly smaller entry on top now knows its right neighbor
    while (stack_depth > 0 &&
           $signed(item.value) > $signed(stack_slots[stack_depth-1].value)) begin
      owe_record(resolved(stack_slots[stack_depth-1], 1'b1, item.value));
      produced++;
      stack_depth--;
    end

    // push; an equal top hands over its own left answer
    if (stack_depth < STACK_DEPTH) begin
      fresh.value = item.value;
      fresh.pos = 5'(next_pos);
      if (stack_depth == 0) begin
        fresh.has_left = 1'b0;
        fresh.left = '0;
      end else if (stack_slots[stack_depth-1].value == item.value) begin
        fresh.has_left = stack_slots[stack_depth-1].has_left;
        fresh.left = stack_slots[stack_depth-1].left;
      end else begin
        fresh.has_left = 1'b1;
        fresh.left = stack_slots[stack_depth-1].value;
      end
      stack_slots[stack_depth] = fresh;
      stack_depth++;
    end
    next_pos++;

    // end of array: flush top down, nothing greater on the right
    if (item.last_element) begin
      while (stack_depth > 0) begin
        owe_record(resolved(stack_slots[stack_depth-1], 1'b0, '0));
        produced++;
        stack_depth--;
      end
      next_pos = 0;
    end

    if (produced > 0) begin
      owed_records[owed_records.size()-1].run_end = 1'b1;
    end
  endfunction

  task automatic queue_element(input logic signed [VAL_W-1:0] v, input logic last);
    in_t item;
    item.value = v;
    item.last_element = last;
    pending_items = {pending_items, item};
    queued_count++;
  endtask

  // one array of len elements, last one marked; past the stack depth this overflows
  task automatic queue_array(input int len, input shape_t shape);
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] run_top;
    logic                    big_finish;
    run_top = $urandom_range(50000, 1000);
    big_finish = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_CLUSTERED: begin
          // narrow range so equal values and short pops are common
          v = $urandom_range(7) - 3;
        end
        SHAPE_FULL: begin
          v = $urandom();
        end
        SHAPE_FALLING: begin
          // builds a deep stack; optionally a large closing value pops all of it
          if (big_finish && i == len - 1 && len > 1) begin
            v = 100000;
          end else begin
            v = run_top;
            run_top = run_top - $urandom_range(3);
          end
        end
        SHAPE_RISING: begin
          run_top = run_top + $urandom_range(3);
          v = run_top;
        end
        default: begin
          case ($urandom_range(4))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = -1;
            3: v = 0;
            default: v = 1;
          endcase
        end
      endcase
      queue_element(v, i == len - 1);
    end
  endtask

  // mostly short arrays, some of full depth, a few that run into overflow
  function automatic int array_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      return STACK_DEPTH;
    end else if (r < 14) begin
      return $urandom_range(STACK_DEPTH + 4, STACK_DEPTH + 1);
    end
    return $urandom_range(10, 1);
  endfunction

  task automatic drain_stimulus();
    while (taken_count != queued_count) @(negedge clk);
  endtask

  // driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_neighbors(in_data);
        taken_count++;
      end
      // a stalled transaction stays put; otherwise load the next one or idle
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every accepted result transaction against the oldest owed record
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_rec = out_data;
        if (owed_records.size() == 0) begin
          report_mismatch("result with nothing owed, index",
                          32'(seen_rec.element_index), 32'd0);
        end else begin
          want_rec = owed_records.pop_front();
          if (seen_rec.element_index !== want_rec.element_index)
            report_mismatch("element_index", 32'(seen_rec.element_index),
                            32'(want_rec.element_index));
          if (seen_rec.has_left !== want_rec.has_left)
            report_mismatch("has_left", 32'(seen_rec.has_left), 32'(want_rec.has_left));
          if (seen_rec.left_value !== want_rec.left_value)
            report_mismatch("left_value", seen_rec.left_value, want_rec.left_value);
          if (seen_rec.has_right !== want_rec.has_right)
            report_mismatch("has_right", 32'(seen_rec.has_right), 32'(want_rec.has_right));
          if (seen_rec.right_value !== want_rec.right_value)
            report_mismatch("right_value", seen_rec.right_value, want_rec.right_value);
          if (seen_rec.status !== want_rec.status)
            report_mismatch("status", 32'(seen_rec.status), 32'(want_rec.status));
          if (seen_rec.run_end !== want_rec.run_end)
            report_mismatch("run_end", 32'(seen_rec.run_end), 32'(want_rec.run_end));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    // phase one: sender idles lightly, receiver stalls about half the time
    send_idle_pct = 20;
    recv_idle_pct = 48;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single element, flushed alone
    queue_element(5, 1'b1);
    // most negative popped by most positive
    queue_element(32'sh8000_0000, 1'b0);
    queue_element(32'sh7fff_ffff, 1'b1);
    // negative against zero
    queue_element(-1, 1'b0);
    queue_element(0, 1'b1);
    // equal values share the left answer; quiet elements give no result
    queue_element(3, 1'b0);
    queue_element(3, 1'b0);
    queue_element(3, 1'b0);
    queue_element(1, 1'b0);
    queue_element(3, 1'b0);
    queue_element(7, 1'b1);
    // pops down to an equal entry
    queue_element(10, 1'b0);
    queue_element(-5, 1'b0);
    queue_element(10, 1'b0);
    queue_element(-5, 1'b1);
    // strictly rising: each element pops the one before
    queue_element(1, 1'b0);
    queue_element(2, 1'b0);
    queue_element(3, 1'b1);

    // a full-length array followed by rejected elements, the final one closing the run
    queue_array($urandom_range(STACK_DEPTH + 4, STACK_DEPTH + 2), SHAPE_CLUSTERED);
    // deepest stack: flushed whole, or popped by a large closing value when one is drawn
    queue_array(STACK_DEPTH, SHAPE_FALLING);
    while (queued_count < 110) queue_array(array_length(), shape_t'($urandom_range(4)));
    drain_stimulus();

    // phase two: roles of the idling swapped
    send_idle_pct = 48;
    recv_idle_pct = 20;
    while (queued_count < 190) queue_array(array_length(), shape_t'($urandom_range(4)));
    drain_stimulus();

    // phase three: back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (queued_count < 270) queue_array(array_length(), shape_t'($urandom_range(4)));
    drain_stimulus();

    // every owed record must show up, then watch for strays a while longer
    while (owed_records.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("nearest_greater_neighbors_top regression: pass");
    end else begin
      $display("nearest_greater_neighbors_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/nng_pkg.sv
sv/nng_ram.sv
sv/nearest_greater_neighbors_top.sv
tb/sv/testbench.sv
